// ===== sv/tjd_pkg.sv =====
// ----------------------------------------------------------------------------
// tjd_pkg
// Shared types and constants for the tracked point jump detector.
// ----------------------------------------------------------------------------
package tjd_pkg;

  localparam int MAX_POINTS   = 4;
  localparam int POINT_FIELDS = 4;
  localparam int LANES        = (MAX_POINTS < POINT_FIELDS) ? MAX_POINTS : POINT_FIELDS;

  localparam int COORD_BITS  = 12;
  localparam int SUBPIX_BITS = 4;
  localparam int NAT_W       = COORD_BITS - SUBPIX_BITS;
  localparam int CNT_W       = 3;
  localparam int SEQ_W       = 32;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int SUM_W  = DIFF_W + $clog2(LANES);
  localparam int RES_W  = SUM_W + 1;
  localparam int NSUM_W = NAT_W + $clog2(LANES);
  localparam int BND_W  = NAT_W + 1;

  localparam int THR_W = 10;
  localparam int LIM_W = THR_W + CNT_W;

  // floor(s/3) == (s*683) >> 11 for s < 2048
  localparam int RECIP3   = 683;
  localparam int RECIP_W  = 10;
  localparam int RECIP_SH = 11;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [THR_W-1:0] THR_RST    = THR_W'(40);
  localparam logic [NAT_W-1:0] MARGIN_RST = NAT_W'(12);
  localparam logic [NAT_W-1:0] WIDTH_RST  = NAT_W'(240);
  localparam logic [NAT_W-1:0] HEIGHT_RST = NAT_W'(176);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_THR    = 2'd0,
    CFG_EDGE_MARGIN = 2'd1,
    CFG_FRAME_W     = 2'd2,
    CFG_FRAME_H     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VERDICT_CLEAN = 2'd0,
    VERDICT_COUNT = 2'd1,
    VERDICT_JUMP  = 2'd2
  } verdict_e;

  // per-lane findings, registered in the lane
  typedef struct packed {
    logic              act;
    logic [DIFF_W-1:0] dx;
    logic [DIFF_W-1:0] dy;
    logic [NAT_W-1:0]  nx;
    logic [NAT_W-1:0]  ny;
    logic              near;
  } lane_t;

  // merged terms fed back to the lanes for the residual test
  typedef struct packed {
    logic [SUM_W-1:0] sx;
    logic [SUM_W-1:0] sy;
    logic [CNT_W-1:0] n;
    logic [LIM_W-1:0] lim;
  } judge_t;

  // final merged result
  typedef struct packed {
    logic             jump;
    logic             near;
    logic [NAT_W-1:0] cx;
    logic [NAT_W-1:0] cy;
  } merge_t;

endpackage

// ===== sv/tjd_lane.sv =====
// ----------------------------------------------------------------------------
// tjd_lane
// One point lane: movement, native position, edge test and residual test.
// ----------------------------------------------------------------------------
module tjd_lane (
  input  logic                            clk_i,
  input  logic                            load_i,
  input  logic                            act_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]  px_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]  py_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]  last_x_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]  last_y_i,
  input  logic [tjd_pkg::NAT_W-1:0]       margin_i,
  input  logic [tjd_pkg::BND_W-1:0]       x_bound_i,
  input  logic [tjd_pkg::BND_W-1:0]       y_bound_i,
  input  tjd_pkg::judge_t                 judge_i,
  output tjd_pkg::lane_t                  lane_o,
  output logic                            jump_o
);
  import tjd_pkg::*;

  lane_t                   lane_d, lane_q;
  logic [NAT_W-1:0]        nx, ny;
  logic                    near_x, near_y;
  logic signed [RES_W-1:0] n_s, dx_s, dy_s, sx_s, sy_s, rx, ry;
  logic [RES_W-1:0]        mx, my, lim_ext;

  always_comb begin
    nx = px_i[COORD_BITS-1:SUBPIX_BITS];
    ny = py_i[COORD_BITS-1:SUBPIX_BITS];
    // bounds are signed: a negative bound flags every point
    near_x = (nx < margin_i) || ($signed({1'b0, nx}) > $signed(x_bound_i));
    near_y = (ny < margin_i) || ($signed({1'b0, ny}) > $signed(y_bound_i));
    lane_d.act  = act_i;
    lane_d.dx   = act_i ? (DIFF_W'(px_i) - DIFF_W'(last_x_i)) : '0;
    lane_d.dy   = act_i ? (DIFF_W'(py_i) - DIFF_W'(last_y_i)) : '0;
    lane_d.nx   = nx;
    lane_d.ny   = ny;
    lane_d.near = act_i && (near_x || near_y);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

  // |n*d - sum_d| > thr*n, exact integer form
  always_comb begin
    n_s     = RES_W'(judge_i.n);
    dx_s    = RES_W'($signed(lane_q.dx));
    dy_s    = RES_W'($signed(lane_q.dy));
    sx_s    = RES_W'($signed(judge_i.sx));
    sy_s    = RES_W'($signed(judge_i.sy));
    rx      = n_s * dx_s - sx_s;
    ry      = n_s * dy_s - sy_s;
    mx      = rx[RES_W-1] ? -rx : rx;
    my      = ry[RES_W-1] ? -ry : ry;
    lim_ext = RES_W'(judge_i.lim);
    jump_o  = lane_q.act && ((mx > lim_ext) || (my > lim_ext));
  end

endmodule

// ===== sv/tjd_merge.sv =====
// ----------------------------------------------------------------------------
// tjd_merge
// Combines lane findings: movement sums, limit, jump/edge flags, mean position.
// ----------------------------------------------------------------------------
module tjd_merge (
  input  logic                        clk_i,
  input  logic                        sum_ld_i,
  input  logic                        res_ld_i,
  input  tjd_pkg::lane_t              lanes_i [tjd_pkg::LANES],
  input  logic [tjd_pkg::LANES-1:0]   jump_i,
  input  logic [tjd_pkg::THR_W-1:0]   thr_i,
  input  logic [tjd_pkg::CNT_W-1:0]   cnt_i,
  output tjd_pkg::judge_t             judge_o,
  output tjd_pkg::merge_t             res_o
);
  import tjd_pkg::*;

  judge_t            judge_q;
  merge_t            res_d, res_q;
  logic [SUM_W-1:0]  sx_d, sy_d;
  logic [NSUM_W-1:0] nxs_d, nys_d, nxs_q, nys_q;
  logic              near_d, near_q;

  function automatic logic [NAT_W-1:0] mean_of(input logic [NSUM_W-1:0] s,
                                               input logic [CNT_W-1:0]  n);
    logic [NSUM_W+RECIP_W-1:0] p;
    p = (NSUM_W+RECIP_W)'(s) * (NSUM_W+RECIP_W)'(RECIP3);
    case (n)
      CNT_W'(1): mean_of = s[NAT_W-1:0];
      CNT_W'(2): mean_of = s[NAT_W:1];
      CNT_W'(3): mean_of = p[RECIP_SH+NAT_W-1:RECIP_SH];
      CNT_W'(4): mean_of = s[NAT_W+1:2];
      default:   mean_of = '0;
    endcase
  endfunction

  always_comb begin
    sx_d   = '0;
    sy_d   = '0;
    nxs_d  = '0;
    nys_d  = '0;
    near_d = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      sx_d   = sx_d + SUM_W'($signed(lanes_i[i].dx));
      sy_d   = sy_d + SUM_W'($signed(lanes_i[i].dy));
      if (lanes_i[i].act) begin
        nxs_d = nxs_d + NSUM_W'(lanes_i[i].nx);
        nys_d = nys_d + NSUM_W'(lanes_i[i].ny);
      end
      near_d = near_d | lanes_i[i].near;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_ld_i) begin
      judge_q.sx  <= sx_d;
      judge_q.sy  <= sy_d;
      judge_q.n   <= cnt_i;
      judge_q.lim <= LIM_W'(thr_i) * LIM_W'(cnt_i);
      nxs_q       <= nxs_d;
      nys_q       <= nys_d;
      near_q      <= near_d;
    end
  end

  assign judge_o = judge_q;

  always_comb begin
    res_d.jump = |jump_i;
    res_d.near = near_q;
    res_d.cx   = mean_of(nxs_q, judge_q.n);
    res_d.cy   = mean_of(nys_q, judge_q.n);
  end

  always_ff @(posedge clk_i) begin
    if (res_ld_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/tracked_point_jump_detector.sv =====
// ----------------------------------------------------------------------------
// tracked_point_jump_detector
// Judges each new camera frame against the previous one for point count
// changes and per-point jumps, flags border points, reports mean position.
// ----------------------------------------------------------------------------
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o  | frame_seq_i, point_count_i, x/y_a..d_i
//  out     | out_valid_o / out_stall_i| accepted_o, verdict_o, near_edge_o,
//          |                          | centre_x_o, centre_y_o
//  cfg     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
//  One frame is in flight at a time. A transfer in is captured, goes through
//  the lane stage, the sum stage and the judge stage, and lands in the output
//  register when the judge stage advances; the next frame is taken the cycle
//  after that. The output register holds a result under out_stall_i while
//  the block takes the next frame; the judge stage then waits for the
//  register. Reset clears the previous-frame state and restores the register
//  defaults.
// ----------------------------------------------------------------------------
module tracked_point_jump_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [tjd_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tjd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // frame in
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [tjd_pkg::SEQ_W-1:0]        frame_seq_i,
  input  logic [tjd_pkg::CNT_W-1:0]        point_count_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]   x_a_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]   y_a_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]   x_b_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]   y_b_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]   x_c_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]   y_c_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]   x_d_i,
  input  logic [tjd_pkg::COORD_BITS-1:0]   y_d_i,
  // result out
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             accepted_o,
  output logic [1:0]                       verdict_o,
  output logic                             near_edge_o,
  output logic [tjd_pkg::NAT_W-1:0]        centre_x_o,
  output logic [tjd_pkg::NAT_W-1:0]        centre_y_o
);
  import tjd_pkg::*;

  // configuration registers
  logic [THR_W-1:0] thr_q;
  logic [NAT_W-1:0] margin_q, width_q, height_q;
  logic [BND_W-1:0] x_bound, y_bound;

  // stage valids: capture, lanes, sums, judge
  logic v0_q, v1_q, v2_q, v3_q;
  logic in_xfer, out_adv;

  // captured frame
  logic [SEQ_W-1:0]      seq_q;
  logic [CNT_W-1:0]      cnt_d, cnt_q;
  logic [COORD_BITS-1:0] px_d [LANES];
  logic [COORD_BITS-1:0] py_d [LANES];
  logic [COORD_BITS-1:0] px_q [LANES];
  logic [COORD_BITS-1:0] py_q [LANES];

  // previous accepted frame
  logic [COORD_BITS-1:0] last_x_q [LANES];
  logic [COORD_BITS-1:0] last_y_q [LANES];
  logic [CNT_W-1:0]      last_cnt_q;
  logic [SEQ_W-1:0]      last_seq_q;
  logic                  have_last_q;

  // frame-level decisions, taken in the lane stage
  logic take_q, consec_q, cchg_q;

  // lanes and merge
  lane_t             lanes [LANES];
  logic [LANES-1:0]  jump;
  judge_t            judge;
  merge_t            res;

  // output register
  logic             out_valid_q;
  logic             acc_q, near_q;
  verdict_e         verdict_d, verdict_q;
  logic [NAT_W-1:0] cx_q, cy_q;

  // ---- configuration -------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= THR_RST;
      margin_q <= MARGIN_RST;
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_JUMP_THR:    thr_q    <= cfg_data_i[THR_W-1:0];
        CFG_EDGE_MARGIN: margin_q <= cfg_data_i[NAT_W-1:0];
        CFG_FRAME_W:     width_q  <= cfg_data_i[NAT_W-1:0];
        CFG_FRAME_H:     height_q <= cfg_data_i[NAT_W-1:0];
        default: ;
      endcase
    end
  end

  // upper edge bounds, signed; may go negative when margin exceeds the frame
  assign x_bound = BND_W'(width_q) - BND_W'(margin_q);
  assign y_bound = BND_W'(height_q) - BND_W'(margin_q);

  // ---- handshake and stage control -----------------------------------------
  assign in_stall_o = v0_q | v1_q | v2_q | v3_q;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign out_adv    = v3_q & (~out_valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= in_xfer;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q | (v3_q & ~out_adv);
    end
  end

  // ---- capture -------------------------------------------------------------
  always_comb begin
    // counts above the lane count saturate
    cnt_d = (point_count_i > CNT_W'(LANES)) ? CNT_W'(LANES) : point_count_i;
    px_d[0] = x_a_i;  py_d[0] = y_a_i;
    px_d[1] = x_b_i;  py_d[1] = y_b_i;
    px_d[2] = x_c_i;  py_d[2] = y_c_i;
    px_d[3] = x_d_i;  py_d[3] = y_d_i;
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      seq_q <= frame_seq_i;
      cnt_q <= cnt_d;
      px_q  <= px_d;
      py_q  <= py_d;
    end
  end

  // new frame, consecutive pair, count change
  always_ff @(posedge clk_i) begin
    if (v0_q) begin
      take_q   <= (seq_q != '0) && (seq_q != last_seq_q);
      consec_q <= have_last_q && (seq_q == last_seq_q + SEQ_W'(1));
      cchg_q   <= cnt_q != last_cnt_q;
    end
  end

  // ---- lanes ---------------------------------------------------------------
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    tjd_lane u_lane (
      .clk_i     (clk_i),
      .load_i    (v0_q),
      .act_i     (cnt_q > CNT_W'(g)),
      .px_i      (px_q[g]),
      .py_i      (py_q[g]),
      .last_x_i  (last_x_q[g]),
      .last_y_i  (last_y_q[g]),
      .margin_i  (margin_q),
      .x_bound_i (x_bound),
      .y_bound_i (y_bound),
      .judge_i   (judge),
      .lane_o    (lanes[g]),
      .jump_o    (jump[g])
    );
  end

  // ---- merge ---------------------------------------------------------------
  tjd_merge u_merge (
    .clk_i    (clk_i),
    .sum_ld_i (v1_q),
    .res_ld_i (v2_q),
    .lanes_i  (lanes),
    .jump_i   (jump),
    .thr_i    (thr_q),
    .cnt_i    (cnt_q),
    .judge_o  (judge),
    .res_o    (res)
  );

  // ---- verdict and output register -----------------------------------------
  // count change wins over a jump; zero points on both sides never jump
  always_comb begin
    if (!consec_q) begin
      verdict_d = VERDICT_CLEAN;
    end else if (cchg_q) begin
      verdict_d = VERDICT_COUNT;
    end else if (res.jump) begin
      verdict_d = VERDICT_JUMP;
    end else begin
      verdict_d = VERDICT_CLEAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // a rejected frame reports all zeros
  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      acc_q     <= take_q;
      verdict_q <= take_q ? verdict_d : VERDICT_CLEAN;
      near_q    <= take_q & res.near;
      cx_q      <= take_q ? res.cx : '0;
      cy_q      <= take_q ? res.cy : '0;
    end
  end

  // previous frame is replaced only by an accepted frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        last_x_q[i] <= '0;
        last_y_q[i] <= '0;
      end
      last_cnt_q  <= '0;
      last_seq_q  <= '0;
      have_last_q <= 1'b0;
    end else if (out_adv && take_q) begin
      last_x_q    <= px_q;
      last_y_q    <= py_q;
      last_cnt_q  <= cnt_q;
      last_seq_q  <= seq_q;
      have_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = acc_q;
  assign verdict_o   = verdict_q;
  assign near_edge_o = near_q;
  assign centre_x_o  = cx_q;
  assign centre_y_o  = cy_q;

endmodule
